// ===== rtl/core/rsgc_pkg.sv =====
// Shared types, widths and command codes for the byte-rate shaper clock.
// Used by the channel interfaces, the shared adder unit and the top level.
// No dependencies.
package rsgc_pkg;

    localparam int TIME_W = 63;
    localparam int RATE_W = 40;
    localparam int LEN_W  = 16;
    localparam int CMD_W  = 2;

    // Bits per byte times nanoseconds per second.
    localparam int               SCALE_W      = 33;
    localparam logic [SCALE_W-1:0] NS_BITS_PER_BYTE = 33'd8_000_000_000;

    // len * 8e9 stays below 2^49; the quotient has at most as many bits.
    localparam int PROD_W = 49;
    localparam int DUR_W  = PROD_W + 1;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    // Width of the shared adder unit.
    localparam int ALU_W = 64;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_CHECK      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHARGE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_IDLE_RESET = 2'd2;

    typedef struct packed {
        logic sub;
    } alu_ctrl_t;

endpackage

// ===== rtl/core/rsgc_cmd_if.sv =====
// Command channel of the shaper clock: valid/ready plus one command beat.
// Depends on rsgc_pkg for the field widths.
interface rsgc_cmd_if
    import rsgc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] now_ns;
    logic [LEN_W-1:0]  packet_length;
    logic              dropped;

    modport source (output valid, command, now_ns, packet_length, dropped, input ready);
    modport sink   (input valid, command, now_ns, packet_length, dropped, output ready);
endinterface

// ===== rtl/core/rsgc_res_if.sv =====
// Result channel of the shaper clock: valid/ready plus the gate and verdict.
// Depends on rsgc_pkg for the field widths.
interface rsgc_res_if
    import rsgc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] gate_ns;
    logic              allowed;

    modport source (output valid, gate_ns, allowed, input ready);
    modport sink   (input valid, gate_ns, allowed, output ready);
endinterface

// ===== rtl/core/rsgc_alu.sv =====
// Shared 64-bit add/subtract unit used by the divide, add and compare steps of the shaper sequencer.
// Depends on rsgc_pkg for the width and the control struct.
module rsgc_alu
    import rsgc_pkg::*;
(
    input  alu_ctrl_t        ctrl,
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic [ALU_W-1:0] sum,
    output logic             carry
);

    logic [ALU_W-1:0] b_eff;

    // On subtract, carry out high means a >= b.
    assign b_eff = ctrl.sub ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, ctrl.sub};

endmodule

// ===== rtl/core/rate_shaper_global_clock.sv =====
// Byte-rate shaper clock. A command beat on cmd (check, charge or idle
// reset) returns one beat on res with the effective gate time and whether
// now has reached it; a nonzero-rate charge or an idle reset may first
// update a primary and a failsafe next-send time. The shaping rate in bits
// per second is to be written through cfg_wr_en and cfg_wr_data only while
// no command is in flight; the block itself does not enforce this. Zero
// disables shaping. A charge with a nonzero rate multiplies the length by
// 8e9 in S_MUL, then divides by the rate one quotient bit per cycle over
// all 49 quotient bits, then runs the saturating time adds and compares;
// the divide steps, adds and compares all run through one shared 64-bit
// adder. Checks and zero-rate charges go straight to S_GATE, S_ALLOW and
// S_DONE; idle resets first pass S_CMPP, and S_CMPF if primary >= now.
// cmd.ready is high only while the sequencer is idle. The result sits in an
// output register, so a new command is accepted while res is stalled; the
// sequencer then waits in its last step until the old beat is taken.
// Reset clears both times and the rate to zero and empties the output.
module rate_shaper_global_clock
    import rsgc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [RATE_W-1:0] cfg_wr_data,
    rsgc_cmd_if.sink          cmd,
    rsgc_res_if.source        res
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_MUL   = 11'b000_0000_0010,
        S_DIV   = 11'b000_0000_0100,
        S_ADDP  = 11'b000_0000_1000,
        S_HALF  = 11'b000_0001_0000,
        S_ADDF  = 11'b000_0010_0000,
        S_CMPP  = 11'b000_0100_0000,
        S_CMPF  = 11'b000_1000_0000,
        S_GATE  = 11'b001_0000_0000,
        S_ALLOW = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [TIME_W-1:0] primary_reg, primary_next;
    logic [TIME_W-1:0] failsafe_reg, failsafe_next;
    logic              res_valid_reg, res_valid_next;

    logic [TIME_W-1:0] now_reg, now_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              drop_reg, drop_next;
    logic [PROD_W-1:0] dq_reg, dq_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [TIME_W-1:0] gate_reg, gate_next;
    logic              allowed_reg, allowed_next;
    logic [TIME_W-1:0] res_gate_reg, res_gate_next;
    logic              res_allowed_reg, res_allowed_next;

    alu_ctrl_t         alu_ctrl;
    logic [ALU_W-1:0]  alu_a;
    logic [ALU_W-1:0]  alu_b;
    logic [ALU_W-1:0]  alu_sum;
    logic              alu_carry;
    logic [TIME_W-1:0] sat_sum;
    logic              accept;
    logic              res_load;
    logic              rate_zero;

    rsgc_alu u_alu (
        .ctrl  (alu_ctrl),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    assign cmd.ready   = (state_reg == S_IDLE);
    assign accept      = cmd.valid && cmd.ready;
    assign res_load    = (state_reg == S_DONE) && (!res_valid_reg || res.ready);
    assign rate_zero   = (rate_reg == '0);
    assign res.valid   = res_valid_reg;
    assign res.gate_ns = res_gate_reg;
    assign res.allowed = res_allowed_reg;

    // Both addends are below 2^63, so bit 63 of the sum flags an overflow.
    assign sat_sum = alu_sum[ALU_W-1] ? TIME_MAX : alu_sum[TIME_W-1:0];

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_ctrl.sub = 1'b1;
        alu_a        = '0;
        alu_b        = '0;
        unique case (state_reg)
            S_DIV:
            begin
                alu_a = {{(ALU_W-RATE_W-1){1'b0}}, rem_reg, dq_reg[PROD_W-1]};
                alu_b = {{(ALU_W-RATE_W){1'b0}}, rate_reg};
            end
            S_ADDP:
            begin
                alu_ctrl.sub = 1'b0;
                alu_a = {1'b0, primary_reg};
                alu_b = {{(ALU_W-PROD_W){1'b0}}, dq_reg};
            end
            S_HALF:
            begin
                alu_ctrl.sub = 1'b0;
                alu_a = {{(ALU_W-PROD_W){1'b0}}, dq_reg};
                alu_b = {{(ALU_W-PROD_W+1){1'b0}}, dq_reg[PROD_W-1:1]};
            end
            S_ADDF:
            begin
                alu_ctrl.sub = 1'b0;
                alu_a = {1'b0, failsafe_reg};
                alu_b = {{(ALU_W-DUR_W){1'b0}}, dur_reg};
            end
            S_CMPP:
            begin
                alu_a = {1'b0, primary_reg};
                alu_b = {1'b0, now_reg};
            end
            S_CMPF:
            begin
                alu_a = {1'b0, failsafe_reg};
                alu_b = {1'b0, now_reg};
            end
            S_GATE:
            begin
                alu_a = {1'b0, primary_reg};
                alu_b = {1'b0, failsafe_reg};
            end
            S_ALLOW:
            begin
                alu_a = {1'b0, now_reg};
                alu_b = {1'b0, gate_reg};
            end
            default:
            begin
                alu_ctrl.sub = 1'b1;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        rate_next        = cfg_wr_en ? cfg_wr_data : rate_reg;
        primary_next     = primary_reg;
        failsafe_next    = failsafe_reg;
        res_valid_next   = res_valid_reg && !res.ready;
        now_next         = now_reg;
        len_next         = len_reg;
        drop_next        = drop_reg;
        dq_next          = dq_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        dur_next         = dur_reg;
        gate_next        = gate_reg;
        allowed_next     = allowed_reg;
        res_gate_next    = res_gate_reg;
        res_allowed_next = res_allowed_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next  = cmd.now_ns;
                    len_next  = cmd.packet_length;
                    drop_next = cmd.dropped;
                    if (cmd.command == CMD_CHARGE && !rate_zero)
                        state_next = S_MUL;
                    else if (cmd.command == CMD_IDLE_RESET)
                        state_next = S_CMPP;
                    else
                        state_next = S_GATE;
                end
            end
            S_MUL:
            begin
                dq_next    = PROD_W'({{SCALE_W{1'b0}}, len_reg} *
                                     {{LEN_W{1'b0}}, NS_BITS_PER_BYTE});
                rem_next   = '0;
                cnt_next   = CNT_W'(PROD_W);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Restoring divide: one quotient bit shifts in per cycle.
                if (alu_carry)
                    rem_next = alu_sum[RATE_W-1:0];
                else
                    rem_next = {rem_reg[RATE_W-2:0], dq_reg[PROD_W-1]};
                dq_next  = {dq_reg[PROD_W-2:0], alu_carry};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = S_ADDP;
            end
            S_ADDP:
            begin
                primary_next = sat_sum;
                state_next   = drop_reg ? S_GATE : S_HALF;
            end
            S_HALF:
            begin
                dur_next   = alu_sum[DUR_W-1:0];
                state_next = S_ADDF;
            end
            S_ADDF:
            begin
                failsafe_next = sat_sum;
                state_next    = S_GATE;
            end
            S_CMPP:
            begin
                if (!alu_carry)
                begin
                    primary_next  = now_reg;
                    failsafe_next = now_reg;
                    state_next    = S_GATE;
                end
                else
                begin
                    state_next = S_CMPF;
                end
            end
            S_CMPF:
            begin
                if (!alu_carry)
                    failsafe_next = now_reg;
                state_next = S_GATE;
            end
            S_GATE:
            begin
                if (rate_zero)
                    gate_next = '0;
                else
                    gate_next = alu_carry ? failsafe_reg : primary_reg;
                state_next = S_ALLOW;
            end
            S_ALLOW:
            begin
                allowed_next = alu_carry;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    res_valid_next   = 1'b1;
                    res_gate_next    = gate_reg;
                    res_allowed_next = allowed_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= '0;
            primary_reg   <= '0;
            failsafe_reg  <= '0;
            res_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            primary_reg   <= primary_next;
            failsafe_reg  <= failsafe_next;
            res_valid_reg <= res_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        len_reg         <= len_next;
        drop_reg        <= drop_next;
        dq_reg          <= dq_next;
        rem_reg         <= rem_next;
        dur_reg         <= dur_next;
        gate_reg        <= gate_next;
        allowed_reg     <= allowed_next;
        res_gate_reg    <= res_gate_next;
        res_allowed_reg <= res_allowed_next;
    end

    // A command beat is taken only once per pass of the sequencer.
    a_one_beat_per_pass: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !cmd.ready)
        else $error("command accepted while the sequencer was busy");

    // With shaping disabled the gate is zero and the packet always passes.
    a_zero_rate_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && rate_zero) |=> (res.gate_ns == '0 && res.allowed))
        else $error("nonzero gate reported with zero rate");

    // A dropped packet must never advance the failsafe time.
    a_drop_skips_failsafe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADDF) |-> !drop_reg)
        else $error("failsafe advanced for a dropped packet");

    // A new result beat only appears out of the final sequencer step.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside the final step");

endmodule
